[rtl/polled_delay_timer_bank_assert.svh]
// Assertion macros for the polled delay timer bank.
// Uses clk and rst_n from the including scope; no other dependencies.
`ifndef POLLED_DELAY_TIMER_BANK_ASSERT_SVH
`define POLLED_DELAY_TIMER_BANK_ASSERT_SVH

// same-cycle implication
`define PTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ptb_pkg.sv]
// Package for the polled delay timer bank: sizes, codes and shared types.
// No dependencies.
`default_nettype none

package ptb_pkg;

  localparam int NUM_TIMERS  = 256;
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W       = $clog2(NUM_TIMERS);
  localparam int ID_W        = 8;
  localparam int CYCLE_W     = 32;

  localparam logic ACT_POLL   = 1'b0;
  localparam logic ACT_CANCEL = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ptb_state_t;

  typedef struct packed {
    logic                   armed;
    logic [COUNT_WIDTH-1:0] count;
  } ptb_entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    ptb_entry_t       wr_data;
  } ptb_mem_req_t;

  typedef struct packed {
    logic             in_ready;
    logic             accept;
    logic             exec;
    logic             commit;
    logic             clear_wr;
    logic [IDX_W-1:0] clear_addr;
  } ptb_ctl_t;

endpackage

`default_nettype wire

[rtl/ptb_if.sv]
// Channel interfaces of the polled delay timer bank: request and result.
// Depends on ptb_pkg.
`default_nettype none

interface ptb_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [ptb_pkg::ID_W-1:0]    timer_id;
  logic [ptb_pkg::CYCLE_W-1:0] cycle_count;

  modport source (output valid, action, timer_id, cycle_count, input ready);
  modport sink   (input valid, action, timer_id, cycle_count, output ready);
endinterface

interface ptb_out_if;
  logic valid;
  logic ready;
  logic expired;

  modport source (output valid, expired, input ready);
  modport sink   (input valid, expired, output ready);
endinterface

`default_nettype wire

[rtl/ptb_mem.sv]
// Timer state memory: one write port, one read port, registered read data.
// Depends on ptb_pkg.
`default_nettype none

module ptb_mem (
  input  wire logic                  clk,
  input  wire ptb_pkg::ptb_mem_req_t req,
  output ptb_pkg::ptb_entry_t        rd_data
);

  ptb_pkg::ptb_entry_t mem [ptb_pkg::NUM_TIMERS];
  ptb_pkg::ptb_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/ptb_ctrl.sv]
// Sequencer: post-reset clearing sweep, then read / modify-write per transfer.
// Depends on ptb_pkg.
`default_nettype none

module ptb_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         out_free,
  output ptb_pkg::ptb_ctl_t ctl
);

  ptb_pkg::ptb_state_t state_r, state_nxt;
  logic [ptb_pkg::IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic clr_last;

  assign clr_last = (clr_idx_r == ptb_pkg::IDX_W'(ptb_pkg::NUM_TIMERS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptb_pkg::ST_CLEAR: begin
        if (clr_last) state_nxt = ptb_pkg::ST_IDLE;
      end
      ptb_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ptb_pkg::ST_EXEC;
      end
      ptb_pkg::ST_EXEC: begin
        if (out_free) state_nxt = ptb_pkg::ST_IDLE;
      end
      default: state_nxt = ptb_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl            = '0;
    ctl.clear_addr = clr_idx_r;
    case (state_r)
      ptb_pkg::ST_CLEAR: begin
        ctl.clear_wr = 1'b1;
      end
      ptb_pkg::ST_IDLE: begin
        ctl.in_ready = 1'b1;
        ctl.accept   = in_valid;
      end
      ptb_pkg::ST_EXEC: begin
        ctl.exec   = 1'b1;
        ctl.commit = out_free;
      end
      default: ctl = '0;
    endcase
  end

  assign clr_idx_nxt = (state_r == ptb_pkg::ST_CLEAR) ?
                       clr_idx_r + ptb_pkg::IDX_W'(1) : clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ptb_pkg::ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/polled_delay_timer_bank.sv]
// Top level of the polled delay timer bank: request latch, update logic,
// result register. Depends on ptb_pkg, ptb_if, ptb_mem, ptb_ctrl and the assert header.
`default_nettype none

// A bank of NUM_TIMERS polled countdown timers held in one synchronous memory
// of {armed, count} words. After reset the block sweeps the memory clear, one
// entry a cycle, with in_ch.ready low. Thereafter each request is a memory
// read on the accepting edge, then the update and write-back once the output
// register is free, with the result loaded into that output register.
// A new request is taken while an earlier result still waits on out_ch, but
// only after the previous request is written back, since the memory reads and
// then writes a single entry. Ids at or above NUM_TIMERS change nothing and
// return expired low.

`include "polled_delay_timer_bank_assert.svh"

module polled_delay_timer_bank (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ptb_in_if.sink     in_ch,
  ptb_out_if.source  out_ch
);

  ptb_pkg::ptb_ctl_t     ctl;
  ptb_pkg::ptb_mem_req_t mem_req;
  ptb_pkg::ptb_entry_t   rd_data;
  ptb_pkg::ptb_entry_t   upd_data;

  logic                            act_r;
  logic [ptb_pkg::IDX_W-1:0]       id_r;
  logic                            in_range_r;
  logic [ptb_pkg::COUNT_WIDTH-1:0] load_r;

  logic out_valid_r, out_valid_nxt;
  logic expired_r;
  logic out_free;
  logic hit;

  assign out_free = !out_valid_r || out_ch.ready;

  ptb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .ctl      (ctl)
  );

  assign in_ch.ready = ctl.in_ready;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      act_r      <= in_ch.action;
      id_r       <= ptb_pkg::IDX_W'(in_ch.timer_id);
      in_range_r <= (int'(in_ch.timer_id) < ptb_pkg::NUM_TIMERS);
      load_r     <= ptb_pkg::COUNT_WIDTH'(in_ch.cycle_count);
    end
  end

  always_comb begin
    upd_data = rd_data;
    hit      = 1'b0;
    if (act_r == ptb_pkg::ACT_CANCEL) begin
      upd_data = '0;
    end else if (!rd_data.armed) begin
      upd_data.armed = 1'b1;
      upd_data.count = load_r;
    end else if (rd_data.count != '0) begin
      upd_data.count = rd_data.count - ptb_pkg::COUNT_WIDTH'(1);
    end else begin
      upd_data.armed = 1'b0;
      hit            = 1'b1;
    end
  end

  always_comb begin
    mem_req         = '0;
    mem_req.rd_en   = ctl.accept;
    mem_req.rd_addr = ptb_pkg::IDX_W'(in_ch.timer_id);
    if (ctl.clear_wr) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = ctl.clear_addr;
      mem_req.wr_data = '0;
    end else begin
      mem_req.wr_en   = ctl.commit && in_range_r;
      mem_req.wr_addr = id_r;
      mem_req.wr_data = upd_data;
    end
  end

  ptb_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      expired_r <= hit && in_range_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.expired = expired_r;

  `PTB_ASSERT_NEXT(a_accept_to_exec, in_ch.valid && in_ch.ready, ctl.exec, "transfer did not start update")
  `PTB_ASSERT_NEXT(a_commit_shows, ctl.commit, out_ch.valid, "result not presented after update")
  `PTB_ASSERT_NEXT(a_cancel_quiet, ctl.commit && (act_r == ptb_pkg::ACT_CANCEL), !out_ch.expired, "cancel reported expiry")
  `PTB_ASSERT_NOW(a_ready_excl, in_ch.ready, !ctl.exec && !ctl.clear_wr, "ready during update or clear")

endmodule

`default_nettype wire

[tb/polled_delay_timer_bank_tb.sv]
`timescale 1ns / 100ps
// Testbench for polled_delay_timer_bank: directed and random polls and cancels,
// each result checked against a behavioural copy of the timer bank.
// Depends on ptb_pkg, ptb_if and the RTL of the block.

module polled_delay_timer_bank_tb;
  import ptb_pkg::*;

  localparam int N_RANDOM   = 1930;
  localparam int LIMIT      = 200000;
  localparam int HOLD_AT    = 1500;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_WAIT = 16;

  class timer_bank_model;
    bit                     armed [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] remaining [NUM_TIMERS];
    bit                     expiry_q [$];
    int                     errors;
    int                     n_polls;
    int                     n_cancels;
    int                     n_results;
    int                     n_expired;

    function void clear();
      foreach (armed[i]) begin
        armed[i]     = 1'b0;
        remaining[i] = '0;
      end
      expiry_q.delete();
    endfunction

    function void note_request(logic act, logic [ID_W-1:0] id, logic [CYCLE_W-1:0] cnt);
      bit hit;
      hit = 1'b0;
      if (act == ACT_CANCEL) n_cancels++;
      else n_polls++;
      if (id < NUM_TIMERS) begin
        if (act == ACT_CANCEL) begin
          armed[id]     = 1'b0;
          remaining[id] = '0;
        end else if (!armed[id]) begin
          armed[id]     = 1'b1;
          remaining[id] = COUNT_WIDTH'(cnt);
        end else if (remaining[id] != 0) begin
          remaining[id] = remaining[id] - 1'b1;
        end else begin
          armed[id] = 1'b0;
          hit       = 1'b1;
        end
      end
      expiry_q.push_back(hit);
    endfunction

    function void check_expiry(logic got);
      bit want;
      if (expiry_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none actual expired=%0b",
                 $time, got);
        return;
      end
      want = expiry_q.pop_front();
      n_results++;
      if (got === 1'b1) n_expired++;
      if (got !== want) begin
        errors++;
        $display("%0t: expired mismatch, expected %0b actual %0b", $time, want, got);
      end
    endfunction

    function int pending();
      return expiry_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ptb_in_if  in_ch ();
  ptb_out_if out_ch ();

  polled_delay_timer_bank i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  timer_bank_model bank = new();

  int              cycles;
  int              rx_cycle;
  int              burst_left;
  bit              no_idle;
  logic [ID_W-1:0] work_ids [6];

  always #1 clk = ~clk;

  // one transfer on the request channel, with bursty idling ahead of it
  task automatic send_item(input logic act, input logic [ID_W-1:0] id,
                           input logic [CYCLE_W-1:0] cnt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = no_idle ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.timer_id    <= id;
    in_ch.cycle_count <= cnt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    bank.note_request(act, id, cnt);
  endtask

  task automatic run_random(input int n);
    logic               act;
    logic [ID_W-1:0]    id;
    logic [CYCLE_W-1:0] cnt;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) begin
        for (int j = 0; j < 6; j++) work_ids[j] = ID_W'($urandom);
        if ((i / 150) % 2 == 1) begin
          work_ids[0] = '0;
          work_ids[1] = '1;
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        act = 1'($urandom_range(0, 1));
        id  = ID_W'($urandom);
        cnt = CYCLE_W'($urandom);
      end else begin
        id  = work_ids[$urandom_range(0, 5)];
        act = ($urandom_range(0, 15) == 0) ? ACT_CANCEL : ACT_POLL;
        cnt = ($urandom_range(0, 3) == 0) ? CYCLE_W'($urandom)
                                          : CYCLE_W'($urandom_range(0, 5));
      end
      no_idle = ((i / 250) % 3 == 1);
      send_item(act, id, cnt);
    end
  endtask

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: phases of steady, random and periodic stalls, one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    rx_cycle = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle == HOLD_AT) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        case ((rx_cycle >> 7) % 4)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ((rx_cycle % 8) < 5);
          default: out_ch.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      bank.check_expiry(out_ch.expired);
  end

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_POLL;
    in_ch.timer_id    <= '0;
    in_ch.cycle_count <= '0;
    burst_left = 0;
    no_idle    = 1'b0;
    bank.clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // id 0: arm at zero, expire, re-arm at one, count down, expire
    send_item(ACT_POLL, 8'd0, 32'd0);
    send_item(ACT_POLL, 8'd0, 32'd0);
    send_item(ACT_POLL, 8'd0, 32'd1);
    send_item(ACT_POLL, 8'd0, 32'd0);
    send_item(ACT_POLL, 8'd0, 32'd0);
    // top id, widest count, cancel while armed, re-arm and expire
    send_item(ACT_POLL,   8'd255, 32'hFFFF_FFFF);
    send_item(ACT_POLL,   8'd255, 32'd0);
    send_item(ACT_CANCEL, 8'd255, 32'hFFFF_FFFF);
    send_item(ACT_POLL,   8'd255, 32'd0);
    send_item(ACT_POLL,   8'd255, 32'hFFFF_FFFF);
    // cancel of an idle timer leaves it idle
    send_item(ACT_CANCEL, 8'd7, 32'd5);
    send_item(ACT_POLL,   8'd7, 32'd2);
    send_item(ACT_POLL,   8'd7, 32'd0);
    send_item(ACT_POLL,   8'd7, 32'd9);
    send_item(ACT_POLL,   8'd7, 32'd0);
    // count on a poll of an armed timer is ignored
    send_item(ACT_POLL, 8'd3, 32'd1);
    send_item(ACT_POLL, 8'd3, 32'hFFFF_FFFF);
    send_item(ACT_POLL, 8'd3, 32'h5555_5555);
    // cancel of an armed timer at zero, then it arms afresh
    send_item(ACT_POLL,   8'd170, 32'd0);
    send_item(ACT_CANCEL, 8'd170, 32'd0);
    send_item(ACT_POLL,   8'd170, 32'hAAAA_AAAA);
    send_item(ACT_CANCEL, 8'd85,  32'd0);

    run_random(N_RANDOM);
    in_ch.valid <= 1'b0;

    while (bank.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d polls and %0d cancels; %0d results checked, %0d expiries.",
             bank.n_polls, bank.n_cancels, bank.n_results, bank.n_expired);
    $display("Receiver held off for %0d cycles once; %0d mismatches.", HOLD_LEN, bank.errors);
    if (bank.errors == 0 && bank.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
